### hdl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and codes for the periodic timer table
// Holds the command and event codes, the slot record type and result limits.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // Command codes carried on in_tuser.
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // Event codes carried on out_tuser.
  localparam logic [1:0] EV_ADD  = 2'd0;
  localparam logic [1:0] EV_DEL  = 2'd1;
  localparam logic [1:0] EV_FIRE = 2'd2;

  // At most this many timers fire on one tick.
  localparam int MAX_RESULTS = 16;
  localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

  // One timer slot as it travels around the ring of cells.
  typedef struct packed {
    logic        valid;
    logic        picked;
    logic [63:0] expiry;
    logic [31:0] period;
    logic [31:0] id;
  } slot_t;

endpackage

### hdl/ptt_cell.sv
// ----------------------------------------------------------------------------
// ptt_cell: one timer slot in the rotating ring
// Takes its neighbor's slot on every shift and can drop its picked mark.
// ----------------------------------------------------------------------------
module ptt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  logic           clr_picked,
  input  ptt_pkg::slot_t d,
  output ptt_pkg::slot_t q
);
  import ptt_pkg::*;

  logic        valid_r;
  logic        picked_r;
  logic [63:0] expiry_r;
  logic [31:0] period_r;
  logic [31:0] id_r;

  // Control bits clear on reset so the table starts empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      picked_r <= 1'b0;
    end else if (shift) begin
      valid_r  <= d.valid;
      picked_r <= d.picked;
    end else if (clr_picked) begin
      picked_r <= 1'b0;
    end
  end

  // Payload follows the ring without reset.
  always_ff @(posedge clk) begin
    if (shift) begin
      expiry_r <= d.expiry;
      period_r <= d.period;
      id_r     <= d.id;
    end
  end

  assign q = '{valid: valid_r, picked: picked_r, expiry: expiry_r,
               period: period_r, id: id_r};

endmodule

### hdl/periodic_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_timer_table: software timer table with periodic reload
// Timer slots sit in a ring of cells that rotates once per search pass.
// ----------------------------------------------------------------------------
// Add and delete: one pass over the ring, then the reply is registered from
// ST_RES, which waits while the output is stalled; the next request is taken
// once the block is back in ST_IDLE.
// Tick: one pass per fired timer plus one, each fire waiting on the output;
// a quiet tick takes a single pass.
// One command is worked at a time.
// Reset empties the table and clears time and id counter; no clearing pass.
module periodic_timer_table #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // delay_ticks[31:0], period_ticks[63:32], timer_id[95:64]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_id[31:0], ok[32], zero fill[39:33]
  output logic [1:0]  out_tuser,  // event_kind[1:0]
  output logic        out_tlast
);
  import ptt_pkg::*;

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RES  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [63:0]         now_r, now_nxt;
  logic [31:0]         next_id_r, next_id_nxt;
  logic [31:0]         new_id_r, new_id_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [31:0]         delay_r, delay_nxt;
  logic [31:0]         period_r, period_nxt;
  logic [31:0]         tid_r, tid_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                found_r, found_nxt;
  logic [63:0]         best_exp_r, best_exp_nxt;
  logic [31:0]         best_id_r, best_id_nxt;
  logic [IW-1:0]       best_idx_r, best_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [IW-1:0]       pend_idx_r, pend_idx_nxt;
  logic [31:0]         pend_id_r, pend_id_nxt;
  logic [FIRE_W-1:0]   fires_r, fires_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_kind_r, out_kind_nxt;
  logic [31:0]         out_id_r, out_id_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic                out_last_r, out_last_nxt;

  slot_t               cell_q [TIMER_SLOTS];
  slot_t               head;
  slot_t               wb;
  logic                shift;
  logic                clr_picked;
  logic [31:0]         nid;
  logic [64:0]         rearm_sum;
  logic                out_free;
  logic                eligible;
  logic                more;
  logic [FIRE_W-1:0]   fires_inc;

  // Ring of slot cells; the head feeds the controller, write-back enters the tail.
  genvar gi;
  generate
    for (gi = 0; gi < TIMER_SLOTS; gi++) begin : g_cell
      slot_t cell_d;
      if (gi == TIMER_SLOTS - 1) begin : g_tail
        assign cell_d = wb;
      end else begin : g_mid
        assign cell_d = cell_q[gi+1];
      end
      ptt_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (shift),
        .clr_picked (clr_picked),
        .d          (cell_d),
        .q          (cell_q[gi])
      );
    end
  endgenerate

  assign head      = cell_q[0];
  assign shift     = (state_r == ST_SCAN);
  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign fires_inc = fires_r + FIRE_W'(1);
  assign more      = found_r && (fires_inc < FIRE_W'(MAX_RESULTS));
  assign rearm_sum = {1'b0, head.expiry} + {33'b0, head.period};

  // Next id skips zero on wrap.
  always_comb begin
    nid = next_id_r + 32'd1;
    if (nid == 32'd0) begin
      nid = 32'd1;
    end
  end

  // A slot may fire if armed, not yet fired this tick and due at the new time.
  assign eligible = head.valid && !head.picked && (head.expiry <= now_r) &&
                    !(pend_r && (idx_r == pend_idx_r));

  // Command sequencer and per-cycle slot update.
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    next_id_nxt   = next_id_r;
    new_id_nxt    = new_id_r;
    cmd_nxt       = cmd_r;
    delay_nxt     = delay_r;
    period_nxt    = period_r;
    tid_nxt       = tid_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    best_exp_nxt  = best_exp_r;
    best_id_nxt   = best_id_r;
    best_idx_nxt  = best_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    pend_id_nxt   = pend_id_r;
    fires_nxt     = fires_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_ok_nxt    = out_ok_r;
    out_last_nxt  = out_last_r;
    wb            = head;
    clr_picked    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (in_tuser != CMD_NONE)) begin
          cmd_nxt    = in_tuser;
          delay_nxt  = in_tdata[31:0];
          period_nxt = in_tdata[63:32];
          tid_nxt    = in_tdata[95:64];
          new_id_nxt = nid;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          pend_nxt   = 1'b0;
          fires_nxt  = '0;
          if (in_tuser == CMD_TICK) begin
            now_nxt = now_r + 64'd1;
          end
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        case (cmd_r)
          CMD_ADD: begin
            // First free slot is armed as it passes the head.
            if (!found_r && !head.valid) begin
              wb.valid  = 1'b1;
              wb.picked = 1'b0;
              wb.expiry = now_r + {32'b0, delay_r};
              wb.period = period_r;
              wb.id     = new_id_r;
              found_nxt = 1'b1;
            end
          end
          CMD_DEL: begin
            // First armed slot with the id is freed.
            if (!found_r && head.valid && (head.id == tid_r)) begin
              wb.valid  = 1'b0;
              found_nxt = 1'b1;
            end
          end
          default: begin
            // Reload or free the timer picked in the previous pass.
            if (pend_r && (idx_r == pend_idx_r)) begin
              wb.picked = 1'b1;
              if (head.period != 32'd0) begin
                wb.expiry = rearm_sum[64] ? '1 : rearm_sum[63:0];
              end else begin
                wb.valid = 1'b0;
              end
            end
            // Keep the earliest due slot by expiry, then id, then index.
            if (eligible && (!found_r ||
                ({head.expiry, head.id} < {best_exp_r, best_id_r}))) begin
              found_nxt    = 1'b1;
              best_exp_nxt = head.expiry;
              best_id_nxt  = head.id;
              best_idx_nxt = idx_r;
            end
          end
        endcase
        idx_nxt = idx_r + IW'(1);
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_RES;
        end
      end

      ST_RES: begin
        unique case (cmd_r)
          CMD_ADD: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = EV_ADD;
              out_id_nxt    = found_r ? new_id_r : 32'd0;
              out_ok_nxt    = found_r;
              out_last_nxt  = 1'b1;
              if (found_r) begin
                next_id_nxt = new_id_r;
              end
              state_nxt = ST_IDLE;
            end
          end
          CMD_DEL: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = EV_DEL;
              out_id_nxt    = 32'd0;
              out_ok_nxt    = found_r;
              out_last_nxt  = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          CMD_TICK: begin
            if (pend_r) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = EV_FIRE;
                out_id_nxt    = pend_id_r;
                out_ok_nxt    = 1'b1;
                out_last_nxt  = !more;
                fires_nxt     = fires_inc;
                if (more) begin
                  pend_idx_nxt = best_idx_r;
                  pend_id_nxt  = best_id_r;
                  found_nxt    = 1'b0;
                  state_nxt    = ST_SCAN;
                end else begin
                  pend_nxt   = 1'b0;
                  clr_picked = 1'b1;
                  state_nxt  = ST_IDLE;
                end
              end
            end else if (found_r) begin
              pend_nxt     = 1'b1;
              pend_idx_nxt = best_idx_r;
              pend_id_nxt  = best_id_r;
              found_nxt    = 1'b0;
              state_nxt    = ST_SCAN;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      next_id_r   <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      fires_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      next_id_r   <= next_id_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      pend_r      <= pend_nxt;
      fires_r     <= fires_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    new_id_r   <= new_id_nxt;
    cmd_r      <= cmd_nxt;
    delay_r    <= delay_nxt;
    period_r   <= period_nxt;
    tid_r      <= tid_nxt;
    best_exp_r <= best_exp_nxt;
    best_id_r  <= best_id_nxt;
    best_idx_r <= best_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_id_r  <= pend_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_ok_r   <= out_ok_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_ok_r, out_id_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

### hdl/ptt_checker.sv
// ----------------------------------------------------------------------------
// ptt_checker: port-level checks for the periodic timer table
// Watches the stream ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module ptt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import ptt_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // A real command keeps the block busy for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != CMD_NONE) |=> !in_tready)
    else $error("block took a request while busy");

  // Add and delete replies are single results.
  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != EV_FIRE) |-> out_tlast)
    else $error("reply not marked last");

  // Delete replies carry id zero and fires are always ok.
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser != EV_DEL) || (out_tdata[31:0] == 32'd0)) &&
      ((out_tuser != EV_FIRE) || out_tdata[32]))
    else $error("result fields inconsistent with event kind");

  // Event kind is one of the three defined codes.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == EV_ADD) || (out_tuser == EV_DEL) ||
      (out_tuser == EV_FIRE))
    else $error("undefined event kind");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (.*);

### verif/periodic_timer_table_test.sv
// ----------------------------------------------------------------------------
// periodic_timer_table_test: self-checking bench for the timer table
// Drives add, delete and tick requests with random gaps, predicts every
// reply and fire from a behavioral copy of the table, and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_timer_table_test;
  import ptt_pkg::*;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] id;
    logic        ok;
    logic        last;
  } timer_event_t;

  // Behavioral timer table that predicts the events of each request.
  class timer_scoreboard;
    logic [63:0]    now_ticks;
    logic [31:0]    id_counter;
    bit             armed [SLOTS];
    logic [63:0]    expiry [SLOTS];
    logic [31:0]    period [SLOTS];
    logic [31:0]    tid [SLOTS];
    timer_event_t   pending[$];
    int             errors;

    function new();
      now_ticks = '0;
      id_counter = '0;
      errors = 0;
      foreach (armed[i]) armed[i] = 0;
    endfunction

    function bit earlier(int a, int b);
      if (expiry[a] != expiry[b]) return expiry[a] < expiry[b];
      if (tid[a] != tid[b]) return tid[a] < tid[b];
      return a < b;
    endfunction

    function int armed_count();
      int n;
      n = 0;
      foreach (armed[i]) n += armed[i];
      return n;
    endfunction

    // Notes an accepted request and queues the events it causes.
    function void note_request(logic [1:0] cmd, logic [31:0] dly, logic [31:0] per,
                               logic [31:0] del_id);
      bit picked [SLOTS];
      int order[$];
      int best, s;
      logic [64:0] sum;
      timer_event_t ev;
      case (cmd)
        CMD_ADD: begin
          ev = '{EV_ADD, 32'd0, 1'b0, 1'b1};
          for (int i = 0; i < SLOTS; i++) begin
            if (!armed[i]) begin
              id_counter = id_counter + 1;
              if (id_counter == 0) id_counter = 1;
              armed[i] = 1;
              expiry[i] = now_ticks + {32'd0, dly};
              period[i] = per;
              tid[i] = id_counter;
              ev.id = id_counter;
              ev.ok = 1'b1;
              break;
            end
          end
          pending = {pending, ev};
        end
        CMD_DEL: begin
          ev = '{EV_DEL, 32'd0, 1'b0, 1'b1};
          for (int i = 0; i < SLOTS; i++) begin
            if (armed[i] && tid[i] == del_id) begin
              armed[i] = 0;
              ev.ok = 1'b1;
              break;
            end
          end
          pending = {pending, ev};
        end
        CMD_TICK: begin
          now_ticks = now_ticks + 1;
          foreach (picked[i]) picked[i] = 0;
          while (order.size() < MAX_RESULTS) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
              if (armed[i] && !picked[i] && expiry[i] <= now_ticks)
                if (best < 0 || earlier(i, best)) best = i;
            if (best < 0) break;
            picked[best] = 1;
            order = {order, best};
          end
          foreach (order[k]) begin
            s = order[k];
            ev = '{EV_FIRE, tid[s], 1'b1, k == order.size() - 1};
            pending = {pending, ev};
            if (period[s] != 0) begin
              sum = {1'b0, expiry[s]} + {33'd0, period[s]};
              expiry[s] = sum[64] ? '1 : sum[63:0];
            end else begin
              armed[s] = 0;
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compares one result with the oldest pending event.
    function void check_result(timer_event_t got);
      timer_event_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind)
        $display("%0t: kind expected %0d actual %0d", $realtime, want.kind, got.kind);
      if (got.id != want.id)
        $display("%0t: id expected %h actual %h", $realtime, want.id, got.id);
      if (got.ok != want.ok)
        $display("%0t: ok expected %0d actual %0d", $realtime, want.ok, got.ok);
      if (got.last != want.last)
        $display("%0t: last expected %0d actual %0d", $realtime, want.last, got.last);
      if (got != want) errors++;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  timer_scoreboard board = new();
  int idle_cycles = 0;
  bit quiet_out = 0;

  periodic_timer_table #(.TIMER_SLOTS(SLOTS)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Result side: sample at the rising edge, random stall at the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result('{out_tuser, out_tdata[31:0], out_tdata[32], out_tlast});
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (!rst_n || quiet_out) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
        while (!out_tvalid) @(posedge clk);
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
          @(negedge clk);
          out_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Leaves in_tvalid high after the handshake; the next falling edge step
  // either presents the next request or drops it.
  task automatic send_request(logic [1:0] cmd, logic [31:0] dly, logic [31:0] per,
                              logic [31:0] del_id);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {del_id, per, dly};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(cmd, dly, per, del_id);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Picks an id that is armed, recent, or random.
  function automatic logic [31:0] pick_id();
    int s;
    s = $urandom_range(0, SLOTS - 1);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return board.id_counter;
      default: return board.armed[s] ? board.tid[s] : board.id_counter - s;
    endcase
  endfunction

  initial begin
    int roll;
    logic [31:0] d, p;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, empty ops, unknown command, table fill and overflow.
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_DEL, '0, '0, 32'hFFFF_FFFF);
    send_request(CMD_NONE, '1, '1, '1);
    send_request(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_request(CMD_ADD, 32'd0, 32'd0, '0);
    send_request(CMD_ADD, 32'd1, 32'hFFFF_FFFF, '0);
    for (int i = 0; i < 14; i++) send_request(CMD_ADD, 32'd2, 32'd1, '0);
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_DEL, '0, '0, 32'd1);
    send_request(CMD_DEL, '0, '0, 32'd3);
    send_request(CMD_TICK, '0, '0, '0);
    // Sender holds while the receiver is stalled, then until every result has come.
    in_tvalid <= 1'b0;
    quiet_out = 1;
    repeat (30) @(negedge clk);
    quiet_out = 0;
    drain();

    for (int n = 0; n < 410; n++) begin
      roll = $urandom_range(0, 99);
      d = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12);
      p = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
      if (roll < 35 && board.armed_count() < SLOTS - 1 || roll < 5)
        send_request(CMD_ADD, d, p, $urandom);
      else if (roll < 55)
        send_request(CMD_DEL, $urandom, $urandom, pick_id());
      else if (roll < 58)
        send_request(CMD_NONE, $urandom, $urandom, $urandom);
      else
        send_request(CMD_TICK, $urandom, $urandom, $urandom);
      if (n % 100 == 50) drain();
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
